// ----- hdl/bc_pkg.sv -----
package bc_pkg;

  // divider word width and input queue depth
  localparam int DIV_W   = 32;
  localparam int Q_DEPTH = 2;

  // fixed constants of the compensation
  localparam logic [31:0] K_B6_OFS   = 32'd4000;
  localparam logic [31:0] K_B7_MUL   = 32'd50000;
  localparam logic [31:0] K_B4_OFS   = 32'd32768;
  localparam logic [31:0] K_P_SQ     = 32'd3038;
  localparam logic [31:0] K_P_LIN    = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_P_OFS    = 32'd3791;
  localparam logic [31:0] K_MSB      = 32'h8000_0000;
  localparam logic [31:0] K_T_MAX    = 32'sd32767;
  localparam logic [31:0] K_T_MIN    = 32'hFFFF_8000;

  // register indexes
  localparam logic [1:0] REG_AC123 = 2'd0;
  localparam logic [1:0] REG_AC456 = 2'd1;
  localparam logic [1:0] REG_B12   = 2'd2;
  localparam logic [1:0] REG_MCMD  = 2'd3;

  // calibration words
  typedef struct packed {
    logic [47:0] ac123;
    logic [47:0] ac456;
    logic [31:0] b12;
    logic [31:0] mcmd;
  } cal_t;

  // one raw reading pair
  typedef struct packed {
    logic [15:0] up;
    logic [15:0] ut;
  } raw_t;

  // sign extend a 16-bit word to 32 bits
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = unsigned'($signed(v) >>> s);
  endfunction

endpackage

// ----- hdl/bc_front.sv -----
module bc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bc_pkg::raw_t  in_raw,
  output logic          q_valid,
  output bc_pkg::raw_t  q_raw,
  input  logic          q_pop
);
  import bc_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  raw_t              mem_r [Q_DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;
  logic              push, pop;

  // queue flags
  assign in_ready = (cnt_r != Q_DEPTH[PW:0]);
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_raw    = mem_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_raw;
    end
  end

endmodule

// ----- hdl/bc_div.sv -----
module bc_div #(
  parameter int W  = bc_pkg::DIV_W,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  in_dvd,
  input  logic [W-1:0]  in_dvs,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  out_quo,
  output logic [SW-1:0] out_side
);
  import bc_pkg::*;

  // one quotient bit per stage, restoring
  logic          v_r    [W];
  logic [W-1:0]  rem_r  [W];
  logic [W-1:0]  dvd_r  [W];
  logic [W-1:0]  dvs_r  [W];
  logic [SW-1:0] side_r [W];

  genvar i;
  generate
    for (i = 0; i < W; i++) begin : g_st
      logic          v_in;
      logic [W-1:0]  rem_in, dvd_in, dvs_in;
      logic [SW-1:0] side_in;
      logic [W:0]    trial;
      logic [W:0]    diff;

      if (i == 0) begin : g_first
        assign v_in    = in_valid;
        assign rem_in  = '0;
        assign dvd_in  = in_dvd;
        assign dvs_in  = in_dvs;
        assign side_in = in_side;
      end else begin : g_next
        assign v_in    = v_r[i-1];
        assign rem_in  = rem_r[i-1];
        assign dvd_in  = dvd_r[i-1];
        assign dvs_in  = dvs_r[i-1];
        assign side_in = side_r[i-1];
      end

      // shift in next dividend bit and try subtracting
      assign trial = {rem_in, dvd_in[W-1]};
      assign diff  = trial - {1'b0, dvs_in};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
          dvd_r[i]  <= {dvd_in[W-2:0], ~diff[W]};
          dvs_r[i]  <= dvs_in;
          side_r[i] <= side_in;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[W-1];
  assign out_quo   = dvd_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

// ----- hdl/bc_back.sv -----
module bc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bc_pkg::cal_t        cal,
  input  logic                q_valid,
  input  bc_pkg::raw_t        q_raw,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [15:0]         res_temp,
  output logic [31:0]         res_press,
  output logic                res_fault
);
  import bc_pkg::*;

  localparam int S1W = 16 + 32 + 1 + 1;
  localparam int S2W = 32 + 1 + 1;

  logic        adv;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  // calibration fields
  assign ac1 = sx16(cal.ac123[47:32]);
  assign ac2 = sx16(cal.ac123[31:16]);
  assign ac3 = sx16(cal.ac123[15:0]);
  assign ac4 = {16'd0, cal.ac456[47:32]};
  assign ac5 = {16'd0, cal.ac456[31:16]};
  assign ac6 = {16'd0, cal.ac456[15:0]};
  assign b1  = sx16(cal.b12[31:16]);
  assign b2  = sx16(cal.b12[15:0]);
  assign mc  = sx16(cal.mcmd[31:16]);
  assign md  = sx16(cal.mcmd[15:0]);

  // whole pipeline moves when the output register can take an item
  assign adv   = !res_valid || res_ready;
  assign q_pop = adv;

  // stage 1: raw temperature product
  logic        v1_r;
  logic [31:0] p1_r;
  logic [15:0] up1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= q_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= ({16'd0, q_raw.ut} - ac6) * ac5;
      up1_r <= q_raw.up;
    end
  end

  // stage 2: x1, divisor and magnitudes for the signed divide
  logic        v2_r, neg2_r, f2_r;
  logic [31:0] x12_r, mn2_r, md2_r;
  logic [15:0] up2_r;
  logic [31:0] x1_a, dv_a, num_a;
  assign x1_a  = asr(p1_r, 5'd15);
  assign dv_a  = x1_a + md;
  assign num_a = mc << 11;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x12_r  <= x1_a;
      mn2_r  <= num_a[31] ? (32'd0 - num_a) : num_a;
      md2_r  <= dv_a[31] ? (32'd0 - dv_a) : dv_a;
      neg2_r <= num_a[31] ^ dv_a[31];
      f2_r   <= (dv_a == 32'd0);
      up2_r  <= up1_r;
    end
  end

  // temperature divide
  logic           d1_v;
  logic [31:0]    d1_q;
  logic [S1W-1:0] d1_side;
  bc_div #(.W(DIV_W), .SW(S1W)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v2_r),
    .in_dvd   (mn2_r),
    .in_dvs   (md2_r),
    .in_side  ({up2_r, x12_r, neg2_r, f2_r}),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_side (d1_side)
  );

  // stage 3: b5 and b6
  logic        v3_r, f3_r;
  logic [31:0] b53_r, b63_r;
  logic [15:0] up3_r;
  logic [31:0] x2_a, b5_a;
  assign x2_a = d1_side[1] ? (32'd0 - d1_q) : d1_q;
  assign b5_a = d1_side[33:2] + x2_a;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= d1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b53_r <= b5_a;
      b63_r <= b5_a - K_B6_OFS;
      f3_r  <= d1_side[0];
      up3_r <= d1_side[49:34];
    end
  end

  // stage 4: products of b6
  logic        v4_r, f4_r;
  logic [31:0] b54_r, sq4_r, pa24_r, pa34_r;
  logic [15:0] up4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq4_r  <= b63_r * b63_r;
      pa24_r <= ac2 * b63_r;
      pa34_r <= ac3 * b63_r;
      b54_r  <= b53_r;
      f4_r   <= f3_r;
      up4_r  <= up3_r;
    end
  end

  // stage 5: products of sq
  logic        v5_r, f5_r;
  logic [31:0] b55_r, pb25_r, pb15_r, x2b5_r, x1c5_r;
  logic [15:0] up5_r;
  logic [31:0] sq_a;
  assign sq_a = asr(sq4_r, 5'd12);
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pb25_r <= b2 * sq_a;
      pb15_r <= b1 * sq_a;
      x2b5_r <= asr(pa24_r, 5'd11);
      x1c5_r <= asr(pa34_r, 5'd13);
      b55_r  <= b54_r;
      f5_r   <= f4_r;
      up5_r  <= up4_r;
    end
  end

  // stage 6: b3 and the b4 factor
  logic        v6_r, f6_r;
  logic [31:0] b56_r, b36_r, s46_r;
  logic [15:0] up6_r;
  logic [31:0] x3b_a, x3c_a;
  assign x3b_a = asr(pb25_r, 5'd11) + x2b5_r;
  assign x3c_a = asr(x1c5_r + asr(pb15_r, 5'd16) + 32'd2, 5'd2);
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b36_r <= asr((ac1 << 2) + x3b_a + 32'd2, 5'd2);
      s46_r <= x3c_a + K_B4_OFS;
      b56_r <= b55_r;
      f6_r  <= f5_r;
      up6_r <= up5_r;
    end
  end

  // stage 7: b4 product and pressure offset
  logic        v7_r, f7_r;
  logic [31:0] b57_r, b4p7_r, b7a7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (adv) v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b4p7_r <= ac4 * s46_r;
      b7a7_r <= {16'd0, up6_r} - b36_r;
      b57_r  <= b56_r;
      f7_r   <= f6_r;
    end
  end

  // stage 8: b4 and b7
  logic        v8_r, f8_r;
  logic [31:0] b58_r, b48_r, b78_r;
  logic [31:0] b4_a;
  assign b4_a = b4p7_r >> 15;
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (adv) v8_r <= v7_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b48_r <= b4_a;
      b78_r <= b7a7_r * K_B7_MUL;
      b58_r <= b57_r;
      f8_r  <= f7_r || (b4_a == 32'd0);
    end
  end

  // pressure divide, doubling before or after by the top bit of b7
  logic           shl_a;
  logic           d2_v;
  logic [31:0]    d2_q;
  logic [S2W-1:0] d2_side;
  assign shl_a = (b78_r >= K_MSB);
  bc_div #(.W(DIV_W), .SW(S2W)) u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v8_r),
    .in_dvd   (shl_a ? b78_r : (b78_r << 1)),
    .in_dvs   (b48_r),
    .in_side  ({b58_r, f8_r, shl_a}),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_side (d2_side)
  );

  // stage 9: correction products
  logic        v9_r, f9_r;
  logic [31:0] b59_r, p9_r, aa9_r, m79_r;
  logic [31:0] p_a, a8_a;
  assign p_a  = d2_side[0] ? (d2_q << 1) : d2_q;
  assign a8_a = asr(p_a, 5'd8);
  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (adv) v9_r <= d2_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      aa9_r <= a8_a * a8_a;
      m79_r <= K_P_LIN * p_a;
      p9_r  <= p_a;
      b59_r <= d2_side[33:2];
      f9_r  <= d2_side[1];
    end
  end

  // stage 10: square term scaling
  logic        v10_r, f10_r;
  logic [31:0] b510_r, p10_r, m310_r, x210_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (adv) v10_r <= v9_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m310_r <= aa9_r * K_P_SQ;
      x210_r <= asr(m79_r, 5'd16);
      p10_r  <= p9_r;
      b510_r <= b59_r;
      f10_r  <= f9_r;
    end
  end

  // output register: final pressure, saturated temperature, fault
  logic        ov_r;
  logic [15:0] ot_r;
  logic [31:0] op_r;
  logic        of_r;
  logic [31:0] pf_a, t_a, ts_a;
  assign pf_a = p10_r + asr(asr(m310_r, 5'd16) + x210_r + K_P_OFS, 5'd4);
  assign t_a  = asr(b510_r + 32'd8, 5'd4);
  always_comb begin
    ts_a = t_a;
    if ($signed(t_a) > $signed(K_T_MAX)) ts_a = K_T_MAX;
    if ($signed(t_a) < $signed(K_T_MIN)) ts_a = K_T_MIN;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= v10_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ot_r <= f10_r ? 16'd0 : ts_a[15:0];
      op_r <= f10_r ? 32'd0 : pf_a;
      of_r <= f10_r;
    end
  end

  assign res_valid = ov_r;
  assign res_temp  = ot_r;
  assign res_press = op_r;
  assign res_fault = of_r;

endmodule

// ----- hdl/barometer_compensation_top.sv -----
// structure: ten arithmetic stages, the output register and two 32-stage
//   one-bit-per-stage dividers; the queue holds an accepted item until the
//   first stage takes it
// throughput: one item per cycle; the back pipeline stalls while a result waits
// reset: synchronous active-low rst_n empties the queue and pipeline and clears
//   the calibration registers to zero
module barometer_compensation_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // raw_temp [15:0], raw_press [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // temp_tenths [15:0], press_pa [47:16]
  output logic [0:0]  out_tuser,  // div_fault [0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import bc_pkg::*;

  cal_t        cal_r;
  logic        wr;
  logic [1:0]  idx;
  raw_t        in_raw, q_raw;
  logic        q_valid, q_pop;
  logic [15:0] r_temp;
  logic [31:0] r_press;
  logic        r_fault;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_AC123: cal_r.ac123 <= cfg_pwdata[47:0];
        REG_AC456: cal_r.ac456 <= cfg_pwdata[47:0];
        REG_B12:   cal_r.b12   <= cfg_pwdata[31:0];
        REG_MCMD:  cal_r.mcmd  <= cfg_pwdata[31:0];
        default:   cal_r       <= cal_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (idx)
      REG_AC123: cfg_prdata = {16'd0, cal_r.ac123};
      REG_AC456: cfg_prdata = {16'd0, cal_r.ac456};
      REG_B12:   cfg_prdata = {32'd0, cal_r.b12};
      REG_MCMD:  cfg_prdata = {32'd0, cal_r.mcmd};
      default:   cfg_prdata = '0;
    endcase
  end

  // front: input item queue
  assign in_raw.ut = in_tdata[15:0];
  assign in_raw.up = in_tdata[31:16];

  bc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_raw  (in_raw),
    .q_valid (q_valid),
    .q_raw   (q_raw),
    .q_pop   (q_pop)
  );

  // back: compensation pipeline
  bc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cal      (cal_r),
    .q_valid  (q_valid),
    .q_raw    (q_raw),
    .q_pop    (q_pop),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res_temp (r_temp),
    .res_press(r_press),
    .res_fault(r_fault)
  );

  assign out_tdata = {r_press, r_temp};
  assign out_tuser = r_fault;

endmodule
